>>> rtl/core/sorted_key_value_merge_sum_assert.svh
// Assertion macros for the sparse merge-sum block.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef SORTED_KEY_VALUE_MERGE_SUM_ASSERT_SVH
`define SORTED_KEY_VALUE_MERGE_SUM_ASSERT_SVH

`ifndef SYNTHESIS
`define SKVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define SKVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SKVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define SKVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/skvm_pkg.sv
// Shared types and constants of the sparse merge-sum block.
// No dependencies; imported by every module of the block.
`default_nettype none

package skvm_pkg;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned SUM_BITS   = VALUE_BITS + 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // command and result queue depths (powers of two)
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_PTR_W  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [15:0] out_key;
    logic [16:0] out_sum;
    logic        last;
    logic        overflow;
  } res_t;

  typedef struct packed {
    kind_e                 op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                  idle;
    logic [CNT_W-1:0]      cnt_a;
    logic [CNT_W-1:0]      cnt_b;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/skvm_front.sv
// Front end: accepts input items, decodes the kind and queues commands.
// Depends on skvm_pkg.
`default_nettype none

module skvm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  skvm_pkg::in_t      item_i,
  output logic               full,
  output logic               cmd_valid_o,
  output skvm_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  import skvm_pkg::*;

  cmd_t                 q_mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 kind_ok;
  logic                 enq;
  logic                 deq;
  cmd_t                 cmd_new;

  assign full        = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  // kind 3 is accepted and dropped here
  assign kind_ok = (item_i.kind == KIND_LOAD_A) || (item_i.kind == KIND_LOAD_B) ||
                   (item_i.kind == KIND_RUN);
  assign enq     = push && !full && kind_ok;
  assign deq     = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new.op    = kind_e'(item_i.kind);
    cmd_new.key   = KEY_BITS'(item_i.key);
    cmd_new.value = VALUE_BITS'(item_i.value);
  end

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + CMD_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + CMD_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CMD_CNT_W'(enq) - CMD_CNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/skvm_merge.sv
// Back end: holds both pair lists in memories, executes loads and runs the
// two-pointer merge. Depends on skvm_pkg.
`default_nettype none

module skvm_merge (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  skvm_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output skvm_pkg::res_t     res_o,
  output skvm_pkg::stat_t    stat_o
);
  import skvm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } pair_t;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic             drop_q, drop_d;

  pair_t mem_a [DEPTH];
  pair_t mem_b [DEPTH];
  pair_t rd_a_q, rd_b_q;
  pair_t wr_pair;

  logic             wr_a, wr_b;
  logic             a_left, b_left, take_a, take_b, take_both;
  logic             adv_a, adv_b, last;
  logic [CNT_W-1:0] ia_nxt, ib_nxt;
  logic [SUM_BITS-1:0] sum;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign wr_pair   = '{key: cmd_i.key, value: cmd_i.value};
  assign wr_a      = cmd_pop_o && (cmd_i.op == KIND_LOAD_A) && (cnt_a_q != CNT_W'(DEPTH));
  assign wr_b      = cmd_pop_o && (cmd_i.op == KIND_LOAD_B) && (cnt_b_q != CNT_W'(DEPTH));

  // list memories: one write port (load), one registered read port (merge)
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[IDX_W-1:0]] <= wr_pair;
    end
    if (wr_b) begin
      mem_b[cnt_b_q[IDX_W-1:0]] <= wr_pair;
    end
    rd_a_q <= mem_a[ia_q[IDX_W-1:0]];
    rd_b_q <= mem_b[ib_q[IDX_W-1:0]];
  end

  // two-pointer decision on the pairs read for the current pointers
  always_comb begin
    a_left    = (ia_q < cnt_a_q);
    b_left    = (ib_q < cnt_b_q);
    take_both = a_left && b_left && (rd_a_q.key == rd_b_q.key);
    take_a    = a_left && (!b_left || (rd_a_q.key < rd_b_q.key));
    take_b    = b_left && (!a_left || (rd_b_q.key < rd_a_q.key));
    adv_a     = take_a || take_both;
    adv_b     = take_b || take_both;
    ia_nxt    = ia_q + CNT_W'(adv_a);
    ib_nxt    = ib_q + CNT_W'(adv_b);
    last      = (ia_nxt == cnt_a_q) && (ib_nxt == cnt_b_q);
    if (take_both) begin
      sum = {1'b0, rd_a_q.value} + {1'b0, rd_b_q.value};
    end else if (take_a) begin
      sum = {1'b0, rd_a_q.value};
    end else begin
      sum = {1'b0, rd_b_q.value};
    end
  end

  assign res_push_o     = (state_q == S_CMP) && !res_full_i;
  assign res_o.out_key  = 16'(take_b ? rd_b_q.key : rd_a_q.key);
  assign res_o.out_sum  = 17'(sum);
  assign res_o.last     = last;
  assign res_o.overflow = drop_q;

  assign stat_o.idle  = (state_q == S_IDLE);
  assign stat_o.cnt_a = cnt_a_q;
  assign stat_o.cnt_b = cnt_b_q;

  always_comb begin
    state_d = state_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    drop_d  = drop_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          case (cmd_i.op)
            KIND_LOAD_A: begin
              if (wr_a) begin
                cnt_a_d = cnt_a_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (wr_b) begin
                cnt_b_d = cnt_b_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            KIND_RUN: begin
              ia_d = '0;
              ib_d = '0;
              if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
                // nothing to merge: clear the flag only
                drop_d = 1'b0;
              end else begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (res_push_o) begin
          ia_d = ia_nxt;
          ib_d = ib_nxt;
          if (last) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/skvm_res_q.sv
// Result queue between the merge engine and the output port.
// Depends on skvm_pkg.
`default_nettype none

module skvm_res_q (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  skvm_pkg::res_t     res_i,
  output logic               full_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output skvm_pkg::res_t     res_o
);
  import skvm_pkg::*;

  res_t                 q_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 enq, deq;

  assign full_o  = (cnt_q == RES_CNT_W'(RES_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = q_mem[rd_ptr_q];
  assign enq     = push_i && !full_o;
  assign deq     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + RES_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + RES_CNT_W'(enq) - RES_CNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_key_value_merge_sum.sv
// Sparse vector addition by two-pointer merge of two loaded pair lists.
// Loads: one item per cycle while the command queue has room; a load is written into
// its list when the idle merge engine pops it. Run: per result the engine does one
// list memory read, then one compare and push, waiting while the result queue is full.
// Reset clears queues, counts, pointers and the overflow flag; list memories are not
// cleared and their contents are only used below the counts.
`default_nettype none
`include "sorted_key_value_merge_sum_assert.svh"

module sorted_key_value_merge_sum (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  skvm_pkg::in_t      item_i,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output skvm_pkg::res_t     result_o
);
  import skvm_pkg::*;

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  logic  res_push, res_full;
  res_t  res;
  stat_t stat;
  logic  cnt_over, last_push, run_done;

  skvm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (item_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  skvm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .stat_o      (stat)
  );

  skvm_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (result_o)
  );

  assign cnt_over  = (stat.cnt_a > CNT_W'(DEPTH)) || (stat.cnt_b > CNT_W'(DEPTH));
  assign last_push = res_push && res.last;
  assign run_done  = stat.idle && (stat.cnt_a == '0) && (stat.cnt_b == '0);

  `SKVM_ASSERT_NEVER(a_res_overrun, clk_i, rst_ni, res_push && res_full, "result queue overrun")
  `SKVM_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_over, "list count beyond depth")
  `SKVM_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, last_push, run_done, "merge busy after last")
  `SKVM_ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, cmd_pop && !stat.idle, "merge busy on pop")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for sorted_key_value_merge_sum: loads two pair lists, runs merges, checks each pair.
// A directed table runs first, then random load/run sequences checked by a merge predictor.
// Depends on skvm_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skvm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 120;
  localparam int TAIL_CYCLES  = 64;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    in_t  item;
    bit   typed;
    int   n_want;
    res_t want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  in_t  item_i = '0;
  logic full;
  logic empty;
  res_t result_o;

  // predictor state
  logic [KEY_BITS-1:0]   a_keys [DEPTH];
  logic [VALUE_BITS-1:0] a_vals [DEPTH];
  logic [KEY_BITS-1:0]   b_keys [DEPTH];
  logic [VALUE_BITS-1:0] b_vals [DEPTH];
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;
  bit dropped = 1'b0;

  res_t merged_q[$];
  res_t pending_pairs[$];
  dir_row_t rows[$];

  bit calm = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  sorted_key_value_merge_sum u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void add_pair(input logic [KEY_BITS-1:0] key,
                                   input logic [SUM_BITS-1:0] sum);
    res_t r;
    r.out_key  = key;
    r.out_sum  = sum;
    r.last     = 1'b0;
    r.overflow = dropped;
    merged_q = {merged_q, r};
  endfunction

  // Update the list state for one item and leave the merged pairs it causes in merged_q.
  function automatic void merge_step(input in_t it);
    int unsigned ia;
    int unsigned ib;
    ia = 0;
    ib = 0;
    merged_q.delete();
    case (it.kind)
      KIND_LOAD_A: begin
        if (cnt_a < DEPTH) begin
          a_keys[cnt_a] = it.key;
          a_vals[cnt_a] = it.value;
          cnt_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_LOAD_B: begin
        if (cnt_b < DEPTH) begin
          b_keys[cnt_b] = it.key;
          b_vals[cnt_b] = it.value;
          cnt_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_RUN: begin
        while (ia < cnt_a && ib < cnt_b) begin
          if (a_keys[ia] < b_keys[ib]) begin
            add_pair(a_keys[ia], {1'b0, a_vals[ia]});
            ia++;
          end else if (a_keys[ia] > b_keys[ib]) begin
            add_pair(b_keys[ib], {1'b0, b_vals[ib]});
            ib++;
          end else begin
            add_pair(a_keys[ia], {1'b0, a_vals[ia]} + {1'b0, b_vals[ib]});
            ia++;
            ib++;
          end
        end
        for (; ia < cnt_a; ia++) add_pair(a_keys[ia], {1'b0, a_vals[ia]});
        for (; ib < cnt_b; ib++) add_pair(b_keys[ib], {1'b0, b_vals[ib]});
        if (merged_q.size() > 0) merged_q[merged_q.size()-1].last = 1'b1;
        cnt_a   = 0;
        cnt_b   = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_pair(input res_t got);
    res_t want;
    if (pending_pairs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected pair: key %h sum %h last %b ovf %b",
                 got.out_key, got.out_sum, got.last, got.overflow);
      return;
    end
    want = pending_pairs.pop_front();
    if (got.out_key !== want.out_key || got.out_sum !== want.out_sum ||
        got.last !== want.last || got.overflow !== want.overflow) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("pair mismatch: exp %h %h %b %b, got %h %h %b %b (key sum last ovf)",
                 want.out_key, want.out_sum, want.last, want.overflow,
                 got.out_key, got.out_sum, got.last, got.overflow);
    end
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [15:0] key,
                                  input logic [15:0] value, input bit typed = 1'b0,
                                  input int n_want = 0, input res_t want = '0);
    dir_row_t r;
    r.item.kind  = kind;
    r.item.key   = key;
    r.item.value = value;
    r.typed      = typed;
    r.n_want     = n_want;
    r.want       = want;
    rows = {rows, r};
  endfunction

  // Hold the item until it is taken; idle at random before raising push.
  task automatic issue(input in_t it, input bit typed = 1'b0, input int n_want = 0,
                       input res_t want = '0);
    while (!calm && $urandom_range(0, 99) < 16) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    if (!push) push <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    merge_step(it);
    if (typed) begin
      for (int j = 0; j < n_want; j++) pending_pairs = {pending_pairs, want};
    end else begin
      foreach (merged_q[j]) pending_pairs = {pending_pairs, merged_q[j]};
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // result side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_pair(result_o);
      pop <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("sorted_key_value_merge_sum test failed");
    $finish;
  end

  initial begin
    in_t it;
    int na;
    int nb;
    int random_items;
    int seq_idx;
    bit sorted;
    logic [15:0] ka;
    logic [15:0] kb;

    random_items = 0;
    seq_idx = 0;

    add_row(KIND_RUN, 16'h0000, 16'h0000, 1'b1, 0);      // both lists empty
    add_row(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 0);   // unused kind: no effect
    add_row(KIND_LOAD_A, 16'hFFFF, 16'hFFFF);
    add_row(KIND_LOAD_B, 16'hFFFF, 16'hFFFF);
    add_row(KIND_RUN, 16'h0000, 16'h0000, 1'b1, 1, res_t'{16'hFFFF, 17'h1FFFE, 1'b1, 1'b0});
    add_row(KIND_LOAD_A, 16'h0000, 16'h0000);
    add_row(KIND_RUN, 16'hFFFF, 16'hFFFF, 1'b1, 1, res_t'{16'h0000, 17'h00000, 1'b1, 1'b0});
    add_row(KIND_LOAD_B, 16'h0001, 16'h0005);
    add_row(KIND_UNUSED, 16'h0000, 16'h0000, 1'b1, 0);
    add_row(KIND_RUN, 16'h0000, 16'h0000, 1'b1, 1, res_t'{16'h0001, 17'h00005, 1'b1, 1'b0});
    // descending list A and a repeated key in list B
    add_row(KIND_LOAD_A, 16'h0005, 16'h1234);
    add_row(KIND_LOAD_A, 16'h0003, 16'h8000);
    add_row(KIND_LOAD_B, 16'h0004, 16'h00FF);
    add_row(KIND_LOAD_B, 16'h0004, 16'hFF00);
    add_row(KIND_RUN, 16'h0000, 16'h0000);
    // interleaved keys with one shared key
    add_row(KIND_LOAD_A, 16'h0001, 16'hAAAA);
    add_row(KIND_LOAD_B, 16'h0002, 16'h5555);
    add_row(KIND_LOAD_A, 16'h0004, 16'h8001);
    add_row(KIND_LOAD_B, 16'h0004, 16'h8002);
    add_row(KIND_LOAD_A, 16'h0009, 16'h0001);
    add_row(KIND_LOAD_B, 16'h000A, 16'h7FFF);
    add_row(KIND_RUN, 16'h0000, 16'h0000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) issue(rows[i].item, rows[i].typed, rows[i].n_want, rows[i].want);
    drain_results();

    while (random_items < RANDOM_ITEMS) begin
      seq_idx++;
      calm = (seq_idx >= 3 && seq_idx <= 5);
      // now and then fill a list past its depth
      if ($urandom_range(0, 7) == 0) begin
        na = $urandom_range(28, 34);
        nb = $urandom_range(0, 34);
      end else begin
        na = $urandom_range(0, 8);
        nb = $urandom_range(0, 8);
      end
      sorted = ($urandom_range(0, 9) != 0);
      ka = 16'($urandom);
      kb = ka;
      while (na > 0 || nb > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          it.kind  = KIND_UNUSED;
          it.key   = 16'($urandom);
          it.value = 16'($urandom);
          issue(it);
        end
        if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
          it.kind = KIND_LOAD_A;
          ka = ka + 16'($urandom_range(0, 3));
          it.key = sorted ? ka : 16'($urandom);
          na--;
        end else begin
          it.kind = KIND_LOAD_B;
          kb = kb + 16'($urandom_range(0, 3));
          it.key = sorted ? kb : 16'($urandom);
          nb--;
        end
        it.value = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        issue(it);
        random_items++;
      end
      // skip the run once in a while so the lists carry over
      if ($urandom_range(0, 11) != 0) begin
        it.kind  = KIND_RUN;
        it.key   = 16'($urandom);
        it.value = 16'($urandom);
        issue(it);
        random_items++;
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    it.kind  = KIND_RUN;
    it.key   = '0;
    it.value = '0;
    issue(it);
    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_key_value_merge_sum test passed");
    end else begin
      $display("sorted_key_value_merge_sum test failed");
    end
    $finish;
  end

endmodule
